### rtl/core/mms_pkg.sv
// mms_pkg: shared types and codes for the min/max stack
// holds action, status and cell operation codes and the cell entry type
// no dependencies
package mms_pkg;

  localparam int DATA_W          = 32;
  localparam int DEF_STACK_DEPTH = 16;

  localparam logic [2:0] ACT_PUSH    = 3'd0;
  localparam logic [2:0] ACT_POP     = 3'd1;
  localparam logic [2:0] ACT_PEEK    = 3'd2;
  localparam logic [2:0] ACT_MIN     = 3'd3;
  localparam logic [2:0] ACT_MAX     = 3'd4;
  localparam logic [2:0] ACT_DUMP_TD = 3'd5;
  localparam logic [2:0] ACT_DUMP_BU = 3'd6;
  localparam logic [2:0] ACT_UNUSED  = 3'd7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_PUSH   = 3'd1;
  localparam logic [2:0] OP_POP    = 3'd2;
  localparam logic [2:0] OP_ROT_UP = 3'd3;
  localparam logic [2:0] OP_ROT_DN = 3'd4;

  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] min;
    logic signed [DATA_W-1:0] max;
  } mms_entry_t;

endpackage

### rtl/core/mms_cell.sv
// mms_cell: one stack slot holding a value and the min/max of itself and all below
// shifts with its neighbors on push/pop, rotates its value during dumps
// depends on mms_pkg
module mms_cell
  import mms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [2:0]               op,
  input  mms_entry_t               up,
  input  mms_entry_t               down,
  input  logic signed [DATA_W-1:0] wrap,
  output mms_entry_t               state
);

  logic                     vld_r, vld_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    min_nxt = min_r;
    max_nxt = max_r;
    case (op)
      OP_PUSH: begin
        vld_nxt = up.vld;
        val_nxt = up.val;
        min_nxt = up.min;
        max_nxt = up.max;
      end
      OP_POP: begin
        vld_nxt = down.vld;
        val_nxt = down.val;
        min_nxt = down.min;
        max_nxt = down.max;
      end
      OP_ROT_UP: begin
        if (vld_r) begin
          val_nxt = down.vld ? down.val : wrap;
        end
      end
      OP_ROT_DN: begin
        if (vld_r) begin
          val_nxt = up.val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    min_r <= min_nxt;
    max_r <= max_nxt;
  end

  assign state.vld = vld_r;
  assign state.val = val_r;
  assign state.min = min_r;
  assign state.max = max_r;

endmodule

### rtl/core/stack_with_min_max_query.sv
// stack_with_min_max_query: bounded lifo stack of signed values with min/max query and dumps
// top level: sequencer plus a chain of mms_cell slots, top of stack in cell 0
// depends on mms_pkg and mms_cell
//
// Each accepted request but the unused action gives its first result in the cycle after
// acceptance, on out_valid for exactly one cycle; the receiver cannot stall, so results must
// be taken as they appear. Push, pop, peek, min and max give one result each, and a new
// request can be accepted every cycle while busy is low. A dump of n entries gives n results
// on consecutive cycles, one per rotation step of the cell chain, and holds busy high until its
// last result is registered. Requests on an empty stack and dropped pushes give one error result.
module stack_with_min_max_query
  import mms_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_action,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data,
  output logic [1:0]               out_status,
  output logic                     out_last
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  logic                     state_r, state_nxt;
  logic                     dir_bu_r, dir_bu_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic                     ovld_r, ovld_nxt;
  logic signed [DATA_W-1:0] odata_r, odata_nxt;
  logic [1:0]               ostat_r, ostat_nxt;
  logic                     olast_r, olast_nxt;

  logic [2:0]               op;
  mms_entry_t               cells [STACK_DEPTH];
  mms_entry_t               head_in;
  mms_entry_t               push_entry;
  logic signed [DATA_W-1:0] bottom_val;
  logic [STACK_DEPTH-1:0]   is_bottom;

  // bottom cell is the last valid one
  always_comb begin
    bottom_val = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (i == STACK_DEPTH - 1) begin
        is_bottom[i] = cells[i].vld;
      end else begin
        is_bottom[i] = cells[i].vld && !cells[i+1].vld;
      end
      bottom_val = bottom_val | (is_bottom[i] ? cells[i].val : '0);
    end
  end

  always_comb begin
    push_entry.vld = 1'b1;
    push_entry.val = in_value;
    push_entry.min = (cells[0].vld && (cells[0].min < in_value)) ? cells[0].min : in_value;
    push_entry.max = (cells[0].vld && (cells[0].max > in_value)) ? cells[0].max : in_value;
    if (op == OP_PUSH) begin
      head_in = push_entry;
    end else begin
      head_in     = '0;
      head_in.val = bottom_val;
    end
  end

  genvar g;
  generate
    for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
      mms_entry_t up_s;
      mms_entry_t down_s;
      if (g == 0) begin : g_head
        assign up_s = head_in;
      end else begin : g_mid
        assign up_s = cells[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_tail
        assign down_s = '0;
      end else begin : g_body
        assign down_s = cells[g+1];
      end
      mms_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .up    (up_s),
        .down  (down_s),
        .wrap  (cells[0].val),
        .state (cells[g])
      );
    end
  endgenerate

  always_comb begin
    op         = OP_HOLD;
    state_nxt  = state_r;
    dir_bu_nxt = dir_bu_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    ovld_nxt   = 1'b0;
    odata_nxt  = '0;
    ostat_nxt  = STAT_OK;
    olast_nxt  = 1'b1;
    if (state_r == ST_DUMP) begin
      ovld_nxt  = 1'b1;
      odata_nxt = dir_bu_r ? bottom_val : cells[0].val;
      op        = dir_bu_r ? OP_ROT_DN : OP_ROT_UP;
      olast_nxt = (rem_r == CNT_ONE);
      rem_nxt   = rem_r - CNT_ONE;
      if (rem_r == CNT_ONE) begin
        state_nxt = ST_IDLE;
      end
    end else if (start) begin
      if (in_action == ACT_PUSH) begin
        ovld_nxt = 1'b1;
        if (count_r == CNT_FULL) begin
          ostat_nxt = STAT_FULL;
        end else begin
          op        = OP_PUSH;
          count_nxt = count_r + CNT_ONE;
        end
      end else if (in_action != ACT_UNUSED) begin
        ovld_nxt = 1'b1;
        if (count_r == '0) begin
          ostat_nxt = STAT_EMPTY;
        end else begin
          case (in_action)
            ACT_POP: begin
              op        = OP_POP;
              count_nxt = count_r - CNT_ONE;
            end
            ACT_PEEK: odata_nxt = cells[0].val;
            ACT_MIN:  odata_nxt = cells[0].min;
            ACT_MAX:  odata_nxt = cells[0].max;
            ACT_DUMP_TD, ACT_DUMP_BU: begin
              dir_bu_nxt = (in_action == ACT_DUMP_BU);
              odata_nxt  = (in_action == ACT_DUMP_BU) ? bottom_val : cells[0].val;
              op         = (in_action == ACT_DUMP_BU) ? OP_ROT_DN : OP_ROT_UP;
              olast_nxt  = (count_r == CNT_ONE);
              rem_nxt    = count_r - CNT_ONE;
              if (count_r != CNT_ONE) begin
                state_nxt = ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_bu_r <= dir_bu_nxt;
    rem_r    <= rem_nxt;
    odata_r  <= odata_nxt;
    ostat_r  <= ostat_nxt;
    olast_r  <= olast_nxt;
  end

  assign busy       = (state_r == ST_DUMP);
  assign out_valid  = ovld_r;
  assign out_data   = odata_r;
  assign out_status = ostat_r;
  assign out_last   = olast_r;

endmodule

### test/stack_result_checker.sv
// stack_result_checker: watches the request and result channels of the min/max stack
// keeps its own copy of the stack, predicts every result and compares field by field
// depends on mms_pkg
`timescale 1ns / 100ps

module stack_result_checker
  import mms_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [2:0]               in_action,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic signed [DATA_W-1:0] out_data,
  input  logic [1:0]               out_status,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending
);

  localparam int PRINT_CAP = 40;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic                     last;
  } stack_result_t;

  logic signed [DATA_W-1:0] held_vals [STACK_DEPTH];
  int                       held_count;
  stack_result_t            expected_results [$];

  task automatic report(input string field, input logic signed [DATA_W-1:0] got,
                        input logic signed [DATA_W-1:0] want);
    if (fail_count < PRINT_CAP)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic add_result(input logic signed [DATA_W-1:0] data, input logic [1:0] status,
                            input logic last);
    stack_result_t r;
    r.data = data;
    r.status = status;
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_stack_results(input logic [2:0] act,
                                       input logic signed [DATA_W-1:0] val);
    logic signed [DATA_W-1:0] extreme;
    if (act == ACT_PUSH) begin
      if (held_count >= STACK_DEPTH) begin
        add_result('0, STAT_FULL, 1'b1);
      end else begin
        held_vals[held_count] = val;
        held_count++;
        add_result('0, STAT_OK, 1'b1);
      end
    end else if (act <= ACT_DUMP_BU) begin
      if (held_count == 0) begin
        add_result('0, STAT_EMPTY, 1'b1);
      end else begin
        case (act)
          ACT_POP: begin
            held_count--;
            add_result('0, STAT_OK, 1'b1);
          end
          ACT_PEEK: add_result(held_vals[held_count-1], STAT_OK, 1'b1);
          ACT_MIN, ACT_MAX: begin
            extreme = held_vals[0];
            for (int i = 1; i < held_count; i++) begin
              if (act == ACT_MIN ? (held_vals[i] < extreme) : (held_vals[i] > extreme))
                extreme = held_vals[i];
            end
            add_result(extreme, STAT_OK, 1'b1);
          end
          ACT_DUMP_TD: begin
            for (int i = 0; i < held_count; i++)
              add_result(held_vals[held_count-1-i], STAT_OK, i == held_count - 1);
          end
          default: begin
            for (int i = 0; i < held_count; i++)
              add_result(held_vals[i], STAT_OK, i == held_count - 1);
          end
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report("unexpected result data", out_data, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want.data)
            report("data", out_data, want.data);
          if (out_status !== want.status)
            report("status", out_status, want.status);
          if (out_last !== want.last)
            report("last", out_last, want.last);
        end
      end
      if (start && !busy)
        predict_stack_results(in_action, in_value);
    end
    pending = expected_results.size();
  end

endmodule

### test/tb_stack_with_min_max_query.sv
// tb_stack_with_min_max_query: drives directed and random requests into the min/max stack
// result checking lives in stack_result_checker; this module gives the verdict
// depends on mms_pkg, stack_with_min_max_query and stack_result_checker
`timescale 1ns / 100ps

module tb_stack_with_min_max_query
  import mms_pkg::*;
;

  localparam int         DEPTH        = DEF_STACK_DEPTH;
  localparam int         RANDOM_ITEMS = 500;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 20;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [2:0]               in_action;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  logic [1:0]               out_status;
  logic                     out_last;
  int                       fail_count;
  int                       pending;
  int                       quiet_cycles;
  int                       level;
  bit                       idle_on;
  bit                       fill_mode;

  stack_with_min_max_query #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_value(in_value),
    .out_valid(out_valid), .out_data(out_data), .out_status(out_status), .out_last(out_last)
  );

  stack_result_checker #(.STACK_DEPTH(DEPTH)) u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_value(in_value),
    .out_valid(out_valid), .out_data(out_data), .out_status(out_status), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // no request taken and no result seen for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_action(input bit filling);
    int r;
    r = $urandom_range(99);
    if (r < (filling ? 55 : 15)) return ACT_PUSH;
    if (r < (filling ? 58 : 55)) return ACT_POP;
    r = $urandom_range(99);
    if (r < 22) return ACT_PEEK;
    if (r < 44) return ACT_MIN;
    if (r < 66) return ACT_MAX;
    if (r < 80) return ACT_DUMP_TD;
    if (r < 94) return ACT_DUMP_BU;
    return ACT_UNUSED;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic request(input logic [2:0] act, input logic signed [DATA_W-1:0] val);
    while (idle_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      in_action <= 3'($urandom);
      in_value <= $urandom;
      @(negedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_PUSH && level < DEPTH) level++;
    if (act == ACT_POP && level > 0) level--;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_PUSH;
    in_value = '0;
    level = 0;
    idle_on = 1'b1;
    fill_mode = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty stack
    request(ACT_POP, '0);
    request(ACT_PEEK, '0);
    request(ACT_MIN, '0);
    request(ACT_MAX, '0);
    request(ACT_DUMP_TD, '0);
    request(ACT_DUMP_BU, '0);
    // extreme values
    request(ACT_PUSH, 32'sh8000_0000);
    request(ACT_PUSH, 32'sh7fff_ffff);
    request(ACT_PUSH, -1);
    request(ACT_PUSH, '0);
    request(ACT_PEEK, -1);
    request(ACT_MIN, '0);
    request(ACT_MAX, '0);
    request(ACT_DUMP_TD, '0);
    request(ACT_DUMP_BU, '0);
    request(ACT_UNUSED, 32'sh5555_aaaa);
    request(ACT_POP, '0);
    request(ACT_PEEK, '0);
    request(ACT_POP, '0);
    request(ACT_POP, '0);
    request(ACT_POP, '0);
    request(ACT_POP, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 150 && n < 300);
      if (n == 100 || n == 400) wait_for_results();
      if (fill_mode && level == DEPTH && $urandom_range(99) < 30) fill_mode = 1'b0;
      else if (!fill_mode && level == 0 && $urandom_range(99) < 40) fill_mode = 1'b1;
      request(pick_action(fill_mode), pick_value());
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
